// ===== rtl/kli_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the keyframe interpolator.
package kli_pkg;

	localparam int TIME_W = 16;
	localparam int LEVEL_W = 16;
	localparam int SLOT_W = 4;
	localparam int SEG_W = 4;
	localparam int COUNT_W = 5;
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = 4;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sh7FFF;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 16'sh8000;

	typedef struct packed {
		logic q_load;
		logic key_wr;
		logic rd_en;
		logic scan_shift;
		logic seg_load;
		logic mul_go;
		logic div_init;
		logic div_step;
		logic res_held;
		logic res_sum;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic match;
	} dp_status_t;

endpackage

// ===== rtl/kli_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module kli_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/kli_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: key table, segment registers, multiplier, serial divider and saturation.
module kli_datapath #(
	parameter int MAX_KEYS = 16
) (
	input  logic                                 clk,
	input  kli_pkg::ctrl_cmd_t                   cmd,
	input  logic [$clog2(MAX_KEYS)-1:0]          rd_addr,
	input  logic [kli_pkg::SLOT_W-1:0]           key_slot,
	input  logic [kli_pkg::TIME_W-1:0]           key_time,
	input  logic signed [kli_pkg::LEVEL_W-1:0]   key_level,
	input  logic [kli_pkg::TIME_W-1:0]           query_time,
	output kli_pkg::dp_status_t                  status,
	output logic signed [kli_pkg::LEVEL_W-1:0]   level_out
);
	import kli_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);
	localparam int RAM_W = TIME_W + LEVEL_W;

	logic [31:0]          slot32;
	logic                 ram_we;
	logic [RAM_W-1:0]     rdata;
	logic [TIME_W-1:0]    cur_time;
	logic [LEVEL_W-1:0]   cur_level;

	logic [TIME_W-1:0]    query_q;
	logic [TIME_W-1:0]    prev_time_q;
	logic [LEVEL_W-1:0]   prev_level_q;
	logic [LEVEL_W-1:0]   v0_q;
	logic [TIME_W-1:0]    div_q;
	logic [TIME_W-1:0]    dt_q;
	logic                 neg_q;
	logic [LEVEL_W-1:0]   mag_q;
	logic                 zw_q;
	logic [31:0]          prod_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    sh_q;
	logic [LEVEL_W-1:0]   res_q;
	logic [LEVEL_W-1:0]   level_q;

	logic [LEVEL_W:0]     dv;
	logic [LEVEL_W:0]     dv_abs;
	logic [TIME_W:0]      trial;
	logic [TIME_W:0]      trial_sub;
	logic                 q_bit;
	logic [TIME_W-1:0]    rem_nxt;
	logic signed [LEVEL_W+1:0] v0x;
	logic signed [LEVEL_W+1:0] qx;
	logic signed [LEVEL_W+1:0] sum;
	logic [LEVEL_W-1:0]   sat;

	assign slot32 = 32'(key_slot);
	assign ram_we = cmd.key_wr && (slot32 < 32'(MAX_KEYS));

	kli_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_KEYS)
	) u_keys (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot32[AW-1:0]),
		.wdata({key_time, key_level}),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	assign cur_time = rdata[RAM_W-1:LEVEL_W];
	assign cur_level = rdata[LEVEL_W-1:0];

	// segment covers the query when start <= t <= end
	assign status.match = (prev_time_q <= query_q) && (cur_time >= query_q);

	assign dv = {cur_level[LEVEL_W-1], cur_level} - {prev_level_q[LEVEL_W-1], prev_level_q};
	assign dv_abs = dv[LEVEL_W] ? ((LEVEL_W+1)'(0) - dv) : dv;

	// restoring divide step; the remainder stays below the divisor
	assign trial = {rem_q, sh_q[TIME_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign q_bit = (trial >= {1'b0, div_q});
	assign rem_nxt = q_bit ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];

	assign v0x = {{2{v0_q[LEVEL_W-1]}}, v0_q};
	assign qx = {2'b00, sh_q};
	assign sum = neg_q ? (v0x - qx) : (v0x + qx);

	always_comb begin
		if (zw_q) begin
			sat = v0_q;
		end else if (sum > 18'sd32767) begin
			sat = LEVEL_MAX;
		end else if (sum < -18'sd32768) begin
			sat = LEVEL_MIN;
		end else begin
			sat = sum[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			query_q <= query_time;
		end
		if (cmd.scan_shift) begin
			prev_time_q <= cur_time;
			prev_level_q <= cur_level;
		end
		if (cmd.seg_load) begin
			v0_q <= prev_level_q;
			div_q <= cur_time - prev_time_q;
			dt_q <= query_q - prev_time_q;
			neg_q <= dv[LEVEL_W];
			mag_q <= dv_abs[LEVEL_W-1:0];
			zw_q <= (cur_time == prev_time_q);
		end
		if (cmd.mul_go) begin
			prod_q <= 32'(mag_q) * 32'(dt_q);
		end
		if (cmd.div_init) begin
			rem_q <= prod_q[31:16];
			sh_q <= prod_q[15:0];
		end
		if (cmd.div_step) begin
			rem_q <= rem_nxt;
			sh_q <= {sh_q[TIME_W-2:0], q_bit};
		end
		if (cmd.res_held) begin
			res_q <= cur_level;
		end
		if (cmd.res_sum) begin
			res_q <= sat;
		end
		if (cmd.out_load) begin
			level_q <= res_q;
		end
	end

	assign level_out = level_q;

endmodule

// ===== rtl/kli_controller.sv =====
`timescale 1ns / 1ps
// Controller: handshakes, segment scan sequencing and divide step counting.
module kli_controller #(
	parameter int MAX_KEYS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [kli_pkg::COUNT_W-1:0]      key_count,
	input  logic                             in_valid,
	input  logic                             req_type,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [kli_pkg::SEG_W-1:0]        segment_used,
	output logic                             held_last,
	output kli_pkg::ctrl_cmd_t               cmd,
	output logic [$clog2(MAX_KEYS)-1:0]      rd_addr,
	input  kli_pkg::dp_status_t              status
);
	import kli_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD    = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DINIT = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_SUM   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	logic [2:0]           state_q, state_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [CW-1:0]        k_q, k_d;
	logic [CW-1:0]        seg_q, seg_d;
	logic                 held_q, held_d;
	logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
	logic                 out_valid_q, out_valid_d;
	logic [SEG_W-1:0]     seg_out_q, seg_out_d;
	logic                 held_out_q, held_out_d;

	logic [31:0]          kc32;
	logic [31:0]          cnt_clamp32;
	logic [31:0]          seg32;
	logic [CW-1:0]        k_next;
	logic                 last_k;

	assign kc32 = 32'(key_count);
	assign cnt_clamp32 = (kc32 == 32'd0) ? 32'd1 :
		((kc32 > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : kc32);
	assign seg32 = 32'(seg_q);
	assign k_next = k_q + CW'(1);
	assign last_k = (k_q == (cnt_q - CW'(1)));

	assign rd_addr = (state_q == S_RD) ? '0 : k_next[AW-1:0];

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		state_d = state_q;
		cnt_d = cnt_q;
		k_d = k_q;
		seg_d = seg_q;
		held_d = held_q;
		div_cnt_d = div_cnt_q;
		out_valid_d = out_valid_q && !out_ready;
		seg_out_d = seg_out_q;
		held_out_d = held_out_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (req_type == REQ_QUERY) begin
						cmd.q_load = 1'b1;
						cnt_d = cnt_clamp32[CW-1:0];
						k_d = '0;
						state_d = S_RD;
					end else begin
						cmd.key_wr = 1'b1;
					end
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if ((k_q != '0) && status.match) begin
					cmd.seg_load = 1'b1;
					seg_d = k_q - CW'(1);
					held_d = 1'b0;
					state_d = S_MUL;
				end else if (last_k) begin
					cmd.res_held = 1'b1;
					seg_d = k_q;
					held_d = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.scan_shift = 1'b1;
					k_d = k_next;
				end
			end
			S_MUL: begin
				cmd.mul_go = 1'b1;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				div_cnt_d = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_LAST) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				cmd.res_sum = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d = 1'b1;
					seg_out_d = seg32[SEG_W-1:0];
					held_out_d = held_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		k_q <= k_d;
		seg_q <= seg_d;
		held_q <= held_d;
		div_cnt_q <= div_cnt_d;
		seg_out_q <= seg_out_d;
		held_out_q <= held_out_d;
	end

	assign out_valid = out_valid_q;
	assign segment_used = seg_out_q;
	assign held_last = held_out_q;

endmodule

// ===== rtl/keyframe_linear_interpolator.sv =====
`timescale 1ns / 1ps
// Top level of the keyframe linear interpolator: register port, controller and datapath.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   input    | in_valid / in_ready       | req_type, key_slot, key_time, key_level,
//            |                           | query_time
//   output   | out_valid / out_ready     | level_out, segment_used, held_last
//   config   | psel / penable / pready   | paddr, pwdata (write), prdata (read)
//
// A key write is taken in the idle state, which the controller does not leave. A query
// walks the key table one key per cycle from the key RAM's registered read port. A query
// that lands in the segment ending at key j then passes through the multiplier, the
// divider load, the one-bit-per-cycle restoring divider, the saturating adder and the
// output register load, and the controller returns to idle as the result is loaded.
// A query that matches no segment holds the last key's level. Reset clears the
// controller state and the output valid; key_count resets to 1 and the key table is
// not cleared. A result waiting on out_ready is held in the output register while the
// next transaction is already accepted; a later query stalls only at its own result
// until the output register frees up.
module keyframe_linear_interpolator #(
	parameter int MAX_KEYS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [1:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [kli_pkg::SLOT_W-1:0]         key_slot,
	input  logic [kli_pkg::TIME_W-1:0]         key_time,
	input  logic signed [kli_pkg::LEVEL_W-1:0] key_level,
	input  logic [kli_pkg::TIME_W-1:0]         query_time,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [kli_pkg::LEVEL_W-1:0] level_out,
	output logic [kli_pkg::SEG_W-1:0]          segment_used,
	output logic                               held_last
);
	import kli_pkg::*;

	localparam logic [1:0] KEY_COUNT_ADDR = 2'd0;

	logic [COUNT_W-1:0]           key_count_q;
	logic                         cfg_wr;
	ctrl_cmd_t                    cmd;
	dp_status_t                   status;
	logic [$clog2(MAX_KEYS)-1:0]  rd_addr;

	// Register port: no wait states, key_count is the only register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == KEY_COUNT_ADDR) ? {{(32 - COUNT_W){1'b0}}, key_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= COUNT_W'(1);
		end else if (cfg_wr && (paddr == KEY_COUNT_ADDR)) begin
			key_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Sequencer: decides what the datapath does each cycle.
	kli_controller #(
		.MAX_KEYS(MAX_KEYS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_count   (key_count_q),
		.in_valid    (in_valid),
		.req_type    (req_type),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.segment_used(segment_used),
		.held_last   (held_last),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.status      (status)
	);

	// Key table and arithmetic.
	kli_datapath #(
		.MAX_KEYS(MAX_KEYS)
	) u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.key_slot  (key_slot),
		.key_time  (key_time),
		.key_level (key_level),
		.query_time(query_time),
		.status    (status),
		.level_out (level_out)
	);

endmodule

// ===== verif/tb_keyframe_linear_interpolator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the keyframe linear interpolator: key loads, queries, register port.
module tb_keyframe_linear_interpolator;

	import kli_pkg::*;

	localparam int MAX_KEYS = 16;
	// Register map: key_count is the only register, at byte address zero.
	localparam logic [1:0] KEY_COUNT_ADDR = 2'd0;
	// Settle this long, longer than the longest query, before any register write.
	localparam int DRAIN_CYCLES = 64;
	// Abort limit for a hung run, set with a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT = 400000;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [1:0]                  paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        in_valid;
	logic                        in_ready;
	logic                        req_type;
	logic [SLOT_W-1:0]           key_slot;
	logic [TIME_W-1:0]           key_time;
	logic signed [LEVEL_W-1:0]   key_level;
	logic [TIME_W-1:0]           query_time;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [LEVEL_W-1:0]   level_out;
	logic [SEG_W-1:0]            segment_used;
	logic                        held_last;

	// One interpolation result as the block should return it.
	typedef struct packed {
		logic signed [LEVEL_W-1:0] level;
		logic [SEG_W-1:0]          seg;
		logic                      held;
	} level_result_t;

	// Shadow copy of the key table and of key_count, updated at each accepted key write and register write.
	logic [TIME_W-1:0]         tbl_time  [MAX_KEYS];
	logic signed [LEVEL_W-1:0] tbl_level [MAX_KEYS];
	logic [COUNT_W-1:0]        key_count_cfg;

	// Results owed by the block, oldest first.
	level_result_t pending_levels[$];

	int mismatch_count;
	int cycle_count;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_left;

	keyframe_linear_interpolator #(
		.MAX_KEYS(MAX_KEYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.key_slot(key_slot),
		.key_time(key_time),
		.key_level(key_level),
		.query_time(query_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level_out(level_out),
		.segment_used(segment_used),
		.held_last(held_last)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Count cycles and abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver: drop out_ready at random, or for a whole hold-off stretch when one is armed.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Print one line per mismatch and count it.
	task automatic note_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Clamp key_count the way the block does: zero means one key, anything above the
	// table size means the whole table.
	function automatic int keys_in_use();
		if (key_count_cfg == 0)
			return 1;
		if (key_count_cfg > MAX_KEYS)
			return MAX_KEYS;
		return int'(key_count_cfg);
	endfunction

	// Search the segments in order and interpolate; hold the last key when none matches.
	function automatic level_result_t interpolate_level(input logic [TIME_W-1:0] t);
		level_result_t r;
		int cnt;
		longint v0;
		longint v1;
		longint sum;
		bit found;
		cnt = keys_in_use();
		found = 1'b0;
		r.level = tbl_level[cnt-1];
		r.seg = SEG_W'(cnt - 1);
		r.held = 1'b1;
		for (int i = 0; i + 1 < cnt && !found; i++) begin
			if (tbl_time[i] <= t && tbl_time[i+1] >= t) begin
				v0 = longint'(tbl_level[i]);
				v1 = longint'(tbl_level[i+1]);
				// Zero-width segment: take the start value instead of dividing by zero.
				if (tbl_time[i+1] == tbl_time[i])
					sum = v0;
				else
					sum = v0 + (longint'(t) - longint'(tbl_time[i])) * (v1 - v0)
						/ (longint'(tbl_time[i+1]) - longint'(tbl_time[i]));
				if (sum > 32767)
					sum = 32767;
				if (sum < -32768)
					sum = -32768;
				r.level = LEVEL_W'(sum);
				r.seg = SEG_W'(i);
				r.held = 1'b0;
				found = 1'b1;
			end
		end
		return r;
	endfunction

	// Offer one transaction from a falling edge, hold it until accepted, then update the
	// shadow table or queue the expected result. Return at the next falling edge.
	task automatic send_transaction(input logic rt, input logic [SLOT_W-1:0] slot,
			input logic [TIME_W-1:0] kt, input logic [LEVEL_W-1:0] kl,
			input logic [TIME_W-1:0] qt);
		level_result_t want;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		key_slot <= slot;
		key_time <= kt;
		key_level <= kl;
		query_time <= qt;
		do @(posedge clk); while (!in_ready);
		if (rt == REQ_WRITE) begin
			tbl_time[slot] = kt;
			tbl_level[slot] = kl;
		end else begin
			want = interpolate_level(qt);
			pending_levels.push_back(want);
		end
		@(negedge clk);
	endtask

	// Key write; the query field carries noise the block must ignore.
	task automatic load_key(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] kt,
			input logic [LEVEL_W-1:0] kl);
		send_transaction(REQ_WRITE, slot, kt, kl, TIME_W'($urandom));
	endtask

	// Query; the key fields carry noise the block must ignore.
	task automatic query_level(input logic [TIME_W-1:0] t);
		send_transaction(REQ_QUERY, SLOT_W'($urandom), TIME_W'($urandom),
			LEVEL_W'($urandom), t);
	endtask

	// Write key_count once the block is idle, then read it back.
	// Upper data bits are random: the register keeps only its low five bits.
	task automatic set_key_count(input logic [COUNT_W-1:0] cnt);
		logic [31:0] wdata;
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		// A trailing key write may still be in flight; let it land.
		repeat (DRAIN_CYCLES) @(negedge clk);
		wdata = $urandom;
		wdata[COUNT_W-1:0] = cnt;
		// Setup phase, then access phase of the write.
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= KEY_COUNT_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		key_count_cfg = cnt;
		@(negedge clk);
		// Back-to-back read of the same register.
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(32-COUNT_W){1'b0}}, cnt})
			note_mismatch($sformatf("key_count read back %0h, wrote %0h", prdata, cnt));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Pick a query time that lands inside a segment most of the time, sometimes on a key,
	// before the first key, after the last key, or anywhere.
	function automatic logic [TIME_W-1:0] pick_query_time();
		int n;
		int k;
		int mode;
		int lo;
		int hi;
		n = keys_in_use();
		mode = $urandom_range(9);
		if (mode <= 5 && n > 1) begin
			k = $urandom_range(n - 2);
			lo = tbl_time[k];
			hi = tbl_time[k+1];
			if (hi >= lo)
				return TIME_W'(lo + $urandom_range(hi - lo));
			return TIME_W'($urandom);
		end
		if (mode == 6)
			return tbl_time[$urandom_range(n - 1)];
		if (mode == 7) begin
			lo = tbl_time[0];
			if (lo > 0)
				return TIME_W'($urandom_range(lo - 1));
			return '0;
		end
		if (mode == 8) begin
			hi = tbl_time[n-1];
			if (hi < 65535)
				return TIME_W'(hi + 1 + $urandom_range(65534 - hi));
			return '1;
		end
		return TIME_W'($urandom);
	endfunction

	// Load keys 0..n-1 in shuffled order: mostly nondecreasing times with some repeats,
	// sometimes spanning the whole time range, sometimes in no order at all.
	task automatic load_random_table(input int n);
		logic [TIME_W-1:0]  times [MAX_KEYS];
		logic [LEVEL_W-1:0] lvl;
		int order [MAX_KEYS];
		int style;
		int base;
		int j;
		int tmp;
		style = $urandom_range(9);
		base = (style == 0) ? 0 : $urandom_range(16'h6000);
		for (int i = 0; i < n; i++) begin
			if (style == 1) begin
				times[i] = TIME_W'($urandom);
			end else begin
				times[i] = TIME_W'(base);
				if ($urandom_range(9) != 0)
					base += $urandom_range(1, (65535 - base) / (n - i));
			end
			order[i] = i;
		end
		if (style == 0)
			times[n-1] = '1;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: begin
					lvl = LEVEL_MIN;
				end
				1: begin
					lvl = LEVEL_MAX;
				end
				default: begin
					lvl = LEVEL_W'($urandom);
				end
			endcase
			load_key(SLOT_W'(order[i]), times[order[i]], lvl);
		end
	endtask

	// After reset only key 0 is in use: every query holds its value.
	task automatic test_single_key_hold();
		load_key(4'd0, 16'h0100, 16'sh7FFF);
		query_level(16'h0000);
		query_level(16'h0100);
		query_level(16'hFFFF);
	endtask

	// One segment across the whole time range and the whole value range.
	task automatic test_full_scale_segment();
		set_key_count(5'd2);
		load_key(4'd0, 16'h0000, LEVEL_MIN);
		load_key(4'd1, 16'hFFFF, LEVEL_MAX);
		query_level(16'h0000);
		query_level(16'h0001);
		query_level(16'h8000);
		query_level(16'hFFFF);
	endtask

	// Zero-width first segment, inner segment, end of the last segment, and misses on
	// both sides of the table.
	task automatic test_zero_width_and_miss();
		set_key_count(5'd4);
		load_key(4'd0, 16'h1000, 16'sh0100);
		load_key(4'd1, 16'h1000, -16'sh0200);
		load_key(4'd2, 16'h2000, 16'sh0400);
		load_key(4'd3, 16'h3000, -16'sh0080);
		query_level(16'h1000);
		query_level(16'h0800);
		query_level(16'h1800);
		query_level(16'h3000);
		query_level(16'h3001);
	endtask

	// key_count of zero behaves as one key.
	task automatic test_count_zero();
		set_key_count(5'd0);
		query_level(16'h2000);
		query_level(16'h0000);
	endtask

	// Phases of: pick a count (extremes included), load a fresh table, then query it with
	// a few stray key writes mixed in.
	task automatic test_random_tables();
		int sent;
		int n;
		int r;
		logic [COUNT_W-1:0] cnt;
		sent = 0;
		while (sent < 520) begin
			r = $urandom_range(19);
			if (r == 0)
				cnt = 5'd0;
			else if (r == 1)
				cnt = 5'd17;
			else if (r == 2)
				cnt = 5'd31;
			else if (r == 3)
				cnt = 5'd16;
			else if (r < 7)
				cnt = 5'd2;
			else
				cnt = COUNT_W'($urandom_range(1, (r < 14) ? 6 : 16));
			set_key_count(cnt);
			n = keys_in_use();
			load_random_table(n);
			sent += n;
			repeat ($urandom_range(10, 30)) begin
				if ($urandom_range(9) == 0)
					load_key(SLOT_W'($urandom), TIME_W'($urandom), LEVEL_W'($urandom));
				else
					query_level(pick_query_time());
				sent++;
			end
		end
	endtask

	// Hold the receiver off for a long stretch while queries keep coming, so the block
	// fills and stalls its input.
	task automatic test_output_backpressure();
		in_valid <= 1'b0;
		@(posedge clk);
		hold_left = 400;
		@(negedge clk);
		repeat (40)
			query_level(pick_query_time());
	endtask

	// No idling on either side.
	task automatic test_back_to_back();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (100) begin
			if ($urandom_range(19) == 0)
				load_key(SLOT_W'($urandom_range(keys_in_use() - 1)), TIME_W'($urandom),
					LEVEL_W'($urandom));
			else
				query_level(pick_query_time());
		end
		tx_idle_pct = 13;
		rx_idle_pct = 13;
	endtask

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		level_result_t want;
		if (out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				note_mismatch($sformatf("unexpected result level %0d seg %0d held %0b",
					level_out, segment_used, held_last));
			end else begin
				want = pending_levels.pop_front();
				if (level_out !== want.level)
					note_mismatch($sformatf("level_out %0d, expected %0d",
						level_out, want.level));
				if (segment_used !== want.seg)
					note_mismatch($sformatf("segment_used %0d, expected %0d",
						segment_used, want.seg));
				if (held_last !== want.held)
					note_mismatch($sformatf("held_last %0b, expected %0b",
						held_last, want.held));
			end
		end
	end

	initial begin
		// Drive every input to a known value and hold reset.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = REQ_WRITE;
		key_slot = '0;
		key_time = '0;
		key_level = '0;
		query_time = '0;
		out_ready = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		tx_idle_pct = 13;
		rx_idle_pct = 13;
		hold_left = 0;
		key_count_cfg = COUNT_W'(1);
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_single_key_hold();
		test_full_scale_segment();
		test_zero_width_and_miss();
		test_count_zero();
		test_random_tables();
		test_output_backpressure();
		test_back_to_back();

		// Drain outstanding results, then watch a while for stray ones.
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/kli_pkg.sv
rtl/kli_ram.sv
rtl/kli_datapath.sv
rtl/kli_controller.sv
rtl/keyframe_linear_interpolator.sv
verif/tb_keyframe_linear_interpolator.sv
